/* hw/rtl/hpwaf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hpwaf_pkg;

    localparam int MAX_WINDOW_DEF = 8;
    localparam int NUM_HANDS_DEF  = 2;
    localparam int POS_W  = 24;
    localparam int CONF_W = 17;
    localparam int GAIN_W = 16;
    localparam int CFG_W  = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILT_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

    localparam logic CMD_POSE = 1'b0;
    localparam logic CMD_LOST = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [1:0]               hand_sel;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic [CONF_W-1:0]        pose_conf;
        logic [4:0]               finger_ext;
    } in_item_t;

    typedef struct packed {
        logic                     kind;
        logic                     hand_out;
        logic signed [POS_W-1:0]  filt_x;
        logic signed [POS_W-1:0]  filt_y;
        logic signed [POS_W-1:0]  filt_z;
        logic [CONF_W-1:0]        filt_conf;
        logic                     is_tracked;
        logic                     is_pointing;
    } out_item_t;

    // control from sequencer to lanes
    typedef struct packed {
        logic clear;   // zero accumulator / start
        logic acc;     // add weighted sample
        logic div;     // start division
    } lane_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/hpwaf_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// One channel: weighted sum by accumulating products, then restoring signed division.
module hpwaf_lane #(
    parameter int DW = 24,
    parameter int SW = 32,
    parameter int DENW = 8
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  hpwaf_pkg::lane_ctl_t         ctl,
    input  wire signed [DW:0]            sample,    // sign-extended sample
    input  wire [DENW-1:0]               weight,
    input  wire [DENW-1:0]               den,
    output logic signed [DW-1:0]         quot,
    output logic                         done
);
    import hpwaf_pkg::*;

    localparam int CW = $clog2(SW + 1);

    logic signed [SW-1:0] sum_reg, sum_next;
    logic [SW-1:0]        mag_reg, mag_next;   // dividend magnitude, shifted out
    logic [SW-1:0]        rem_reg, rem_next;
    logic                 neg_reg, neg_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic signed [DW+DENW+1:0] prod;
    logic [SW-1:0]        trial;

    assign prod = sample * $signed({1'b0, weight});
    assign trial = {rem_reg[SW-2:0], mag_reg[SW-1]} - SW'(den);

    always_comb
    begin
        sum_next  = sum_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctl.clear)
        begin
            sum_next  = '0;
            busy_next = 1'b0;
        end
        else if (ctl.acc)
        begin
            sum_next = sum_reg + SW'(prod);
        end
        else if (ctl.div)
        begin
            neg_next  = sum_reg[SW-1];
            mag_next  = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
            rem_next  = '0;
            cnt_next  = CW'(SW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SW-1] || rem_reg[SW-1])
            begin
                rem_next = trial;
                mag_next = {mag_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[SW-2:0], mag_reg[SW-1]};
                mag_next = {mag_reg[SW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    logic signed [SW-1:0] q_signed;
    assign q_signed = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
    assign quot = q_signed[DW-1:0];
    assign done = !busy_reg;

endmodule
`default_nettype wire

/* hw/rtl/hand_pose_weighted_average_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Hand lost or filter off: the item passes through SCALE and OUT to out_valid.
// Filtered pose: the window is read and weighted in ACC, then DIV starts a
// 48-step serial divide running in each of the four channel lanes.
// Invalid hand: no result; the FSM returns to IDLE and is ready again.
// One item at a time; the next is taken once the result leaves the output register.
// Reset clears fill counts, ring pointers, config to defaults; history is not cleared.
module hand_pose_weighted_average_filter #(
    parameter int MAX_WINDOW = hpwaf_pkg::MAX_WINDOW_DEF,
    parameter int NUM_HANDS  = hpwaf_pkg::NUM_HANDS_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  hpwaf_pkg::in_item_t           in_data,
    output logic                          out_valid,
    input  wire                           out_ready,
    output hpwaf_pkg::out_item_t          out_data,
    input  wire                           cfg_we,
    input  wire [hpwaf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [hpwaf_pkg::CFG_W-1:0]    cfg_wdata
);
    import hpwaf_pkg::*;

    localparam int SW   = 48;
    localparam int SLW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FW   = $clog2(MAX_WINDOW + 1);
    localparam int HW   = (NUM_HANDS > 1) ? $clog2(NUM_HANDS) : 1;
    localparam int DEPTH = NUM_HANDS * MAX_WINDOW;
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DENW = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_PUSH = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [GAIN_W-1:0] gain_reg;
    logic              fen_reg;
    logic [3:0]        wsize_reg;
    logic [CONF_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_W'(256);
            fen_reg   <= 1'b1;
            wsize_reg <= 4'd5;
            thr_reg   <= CONF_W'(45875);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:      gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_FILT_EN:   fen_reg   <= cfg_wdata[0];
                REG_WIN_SIZE:  wsize_reg <= cfg_wdata[3:0];
                REG_THRESHOLD: thr_reg   <= cfg_wdata[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    logic [FW-1:0] eff_w;
    always_comb
    begin
        if (wsize_reg == 4'd0)
            eff_w = FW'(1);
        else if (32'(wsize_reg) > MAX_WINDOW)
            eff_w = FW'(MAX_WINDOW);
        else
            eff_w = FW'(wsize_reg);
    end

    logic [2:0]   state_reg, state_next;
    in_item_t     item_reg;
    logic [HW-1:0] hand_reg;
    logic [FW-1:0] fill_reg [NUM_HANDS];
    logic [SLW-1:0] old_reg [NUM_HANDS];
    logic [FW-1:0] idx_reg;
    logic [DENW-1:0] den_reg;
    logic signed [POS_W-1:0] sx_reg, sy_reg, sz_reg;
    out_item_t    out_reg;
    logic         ov_reg;

    // history memory: x,y,z,conf packed
    localparam int MW = 3 * POS_W + CONF_W;
    logic [MW-1:0] hist_mem [DEPTH];
    logic [MW-1:0] rd_reg;
    logic          rd_ok_reg;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    // saturating Q8.8 scale, truncate toward zero
    function automatic logic signed [POS_W-1:0] scale(input logic signed [POS_W-1:0] p,
                                                      input logic [GAIN_W-1:0] g);
        logic signed [POS_W+GAIN_W:0] pr;
        logic signed [POS_W+GAIN_W:0] q;
        pr = p * $signed({1'b0, g});
        q  = (pr < 0) ? -((-pr) >>> 8) : (pr >>> 8);
        if (q > $signed((POS_W+GAIN_W+1)'(8388607)))
            return POS_W'(8388607);
        else if (q < -$signed((POS_W+GAIN_W+1)'(8388608)))
            return POS_W'(-8388608);
        else
            return q[POS_W-1:0];
    endfunction

    logic [FW-1:0] fill_h;
    logic [SLW-1:0] old_h;
    assign fill_h = fill_reg[hand_reg];
    assign old_h  = old_reg[hand_reg];

    function automatic logic [SLW-1:0] wrap(input logic [FW:0] v);
        logic [FW:0] r;
        r = (32'(v) >= MAX_WINDOW) ? v - (FW+1)'(MAX_WINDOW) : v;
        return r[SLW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr(input logic [HW-1:0] h, input logic [SLW-1:0] s);
        return AW'(32'(h) * MAX_WINDOW + 32'(s));
    endfunction

    // push bookkeeping
    logic [SLW-1:0] wslot;
    logic [FW-1:0]  fill_p;
    logic [SLW-1:0] old_p;
    logic [FW:0]    excess;
    always_comb
    begin
        if (32'(fill_h) < MAX_WINDOW)
        begin
            wslot  = wrap({1'b0, FW'(old_h)} + {1'b0, fill_h});
            fill_p = fill_h + 1'b1;
            old_p  = old_h;
        end
        else
        begin
            wslot  = old_h;
            fill_p = fill_h;
            old_p  = wrap({1'b0, FW'(old_h)} + (FW+1)'(1));
        end
        if (fill_p > eff_w)
        begin
            excess = {1'b0, fill_p} - {1'b0, eff_w};
            old_p  = wrap({1'b0, FW'(old_p)} + excess);
            fill_p = eff_w;
        end
        else
            excess = '0;
    end

    lane_ctl_t ctl;
    logic [3:0] ldone;
    logic signed [POS_W-1:0] qx, qy, qz;
    logic signed [CONF_W+7:0] qcw;
    logic [SLW-1:0] rslot;
    assign rslot = wrap({1'b0, FW'(old_h)} + {1'b0, idx_reg});

    always_comb
    begin
        ctl = '0;
        ctl.clear = (state_reg == S_PUSH);
        ctl.acc   = (state_reg == S_ACC) && rd_ok_reg;
        ctl.div   = (state_reg == S_DIV);
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= hist_mem[addr(hand_reg, rslot)];
        if (state_reg == S_PUSH)
            hist_mem[addr(hand_reg, wslot)] <= {sx_reg, sy_reg, sz_reg, item_reg.pose_conf};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid && in_ready) state_next = S_SCALE;
            S_SCALE:
            begin
                if (32'(item_reg.hand_sel) >= NUM_HANDS)
                    state_next = S_IDLE;
                else if (item_reg.cmd == CMD_LOST || !fen_reg)
                    state_next = S_OUT;
                else
                    state_next = S_PUSH;
            end
            S_PUSH:  state_next = S_ACC;
            S_ACC:   if (rd_ok_reg && idx_reg == fill_h) state_next = S_DIV;
            S_DIV:   state_next = S_WAIT;
            S_WAIT:  if (&ldone) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            rd_ok_reg <= 1'b0;
            idx_reg   <= '0;
            for (int h = 0; h < NUM_HANDS; h++)
            begin
                fill_reg[h] <= '0;
                old_reg[h]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && out_ready)
                ov_reg <= 1'b0;
            if (state_reg == S_OUT)
                ov_reg <= 1'b1;
            if (state_reg == S_SCALE && item_reg.cmd == CMD_LOST
                && 32'(item_reg.hand_sel) < NUM_HANDS)
            begin
                fill_reg[hand_reg] <= '0;
                old_reg[hand_reg]  <= '0;
            end
            if (state_reg == S_PUSH)
            begin
                fill_reg[hand_reg] <= fill_p;
                old_reg[hand_reg]  <= old_p;
                idx_reg   <= '0;
                rd_ok_reg <= 1'b0;
            end
            else if (state_reg == S_ACC)
            begin
                // read for idx_reg issued this cycle; data valid next
                rd_ok_reg <= 1'b1;
                if (rd_ok_reg || idx_reg == '0)
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // weight is one above the index of the sample in rd_reg
    logic [DENW-1:0] wgt;
    assign wgt = DENW'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
            hand_reg <= in_data.hand_sel[HW-1:0];
        end
        if (state_reg == S_SCALE)
        begin
            sx_reg <= scale(item_reg.pos_x, gain_reg);
            sy_reg <= scale(item_reg.pos_y, gain_reg);
            sz_reg <= scale(item_reg.pos_z, gain_reg);
        end
        if (state_reg == S_PUSH)
            den_reg <= DENW'((32'(fill_p) * (32'(fill_p) + 1)) >> 1);
        if (state_reg == S_OUT)
        begin
            if (item_reg.cmd == CMD_LOST)
                out_reg <= {CMD_LOST, item_reg.hand_sel[0], (3*POS_W+CONF_W+2)'(0)};
            else
            begin
                out_reg.kind        <= CMD_POSE;
                out_reg.hand_out    <= item_reg.hand_sel[0];
                out_reg.is_tracked  <= item_reg.pose_conf > thr_reg;
                out_reg.is_pointing <= item_reg.finger_ext[1] && !item_reg.finger_ext[2];
                if (fen_reg)
                begin
                    out_reg.filt_x    <= qx;
                    out_reg.filt_y    <= qy;
                    out_reg.filt_z    <= qz;
                    out_reg.filt_conf <= qcw[CONF_W-1:0];
                end
                else
                begin
                    out_reg.filt_x    <= sx_reg;
                    out_reg.filt_y    <= sy_reg;
                    out_reg.filt_z    <= sz_reg;
                    out_reg.filt_conf <= item_reg.pose_conf;
                end
            end
        end
    end

    hpwaf_lane #(.DW(POS_W), .SW(SW), .DENW(DENW)) u_lane_x (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .sample({rd_reg[MW-1], rd_reg[MW-1 -: POS_W]}),
        .weight(wgt), .den(den_reg), .quot(qx), .done(ldone[0]));
    hpwaf_lane #(.DW(POS_W), .SW(SW), .DENW(DENW)) u_lane_y (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .sample({rd_reg[MW-1-POS_W], rd_reg[MW-1-POS_W -: POS_W]}),
        .weight(wgt), .den(den_reg), .quot(qy), .done(ldone[1]));
    hpwaf_lane #(.DW(POS_W), .SW(SW), .DENW(DENW)) u_lane_z (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .sample({rd_reg[CONF_W+POS_W-1], rd_reg[CONF_W+POS_W-1 -: POS_W]}),
        .weight(wgt), .den(den_reg), .quot(qz), .done(ldone[2]));
    hpwaf_lane #(.DW(CONF_W+8), .SW(SW), .DENW(DENW)) u_lane_c (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .sample({9'd0, rd_reg[CONF_W-1:0]}),
        .weight(wgt), .den(den_reg), .quot(qcw), .done(ldone[3]));

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input taken while busy");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> (fill_h <= FW'(MAX_WINDOW)))
        else $error("fill count over depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(out_reg)))
        else $error("result dropped while stalled");

endmodule
`default_nettype wire
